FILE: sv/gcrl_pkg.sv
// Shared types and constants of the great-circle route length core.
package gcrl_pkg;

   localparam int DEFAULT_ANGLE_FRAC_BITS = 20;
   localparam int LAT_W = 28;
   localparam int LON_W = 29;
   localparam int DLON_W = 30;
   localparam int SEG_W = 25;
   localparam int TOTAL_W = 40;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [1:0] {
      KIND_START   = 2'd0,
      KIND_FIRST   = 2'd1,
      KIND_SEGMENT = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic signed [LAT_W-1:0]   lat1;
      logic signed [LAT_W-1:0]   lat2;
      logic signed [DLON_W-1:0]  dlon;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

FILE: sv/gcrl_front.sv
// Input side: accepts waypoint transfers, keeps the previous waypoint and classifies each item.
module gcrl_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [gcrl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                      req_tuser,
   input  gcrl_pkg::queue_stat_type  q_stat,
   output logic                      push,
   output gcrl_pkg::entry_type       push_entry
);

   logic signed [gcrl_pkg::LAT_W-1:0] prev_lat_ff, prev_lat_in;
   logic signed [gcrl_pkg::LON_W-1:0] prev_lon_ff, prev_lon_in;
   logic have_ff, have_in;
   logic signed [gcrl_pkg::LAT_W-1:0] lat;
   logic signed [gcrl_pkg::LON_W-1:0] lon;

   assign lat = req_tdata[gcrl_pkg::LAT_W-1:0];
   assign lon = req_tdata[gcrl_pkg::LAT_W+gcrl_pkg::LON_W-1:gcrl_pkg::LAT_W];
   assign req_tready = !q_stat.full;
   assign push = req_tvalid && req_tready;

   always_comb begin
      push_entry.lat1 = prev_lat_ff;
      push_entry.lat2 = lat;
      push_entry.dlon = gcrl_pkg::DLON_W'(lon) - gcrl_pkg::DLON_W'(prev_lon_ff);
      if (req_tuser) begin
         push_entry.kind = gcrl_pkg::KIND_START;
      end else if (have_ff) begin
         push_entry.kind = gcrl_pkg::KIND_SEGMENT;
      end else begin
         push_entry.kind = gcrl_pkg::KIND_FIRST;
      end
      prev_lat_in = prev_lat_ff;
      prev_lon_in = prev_lon_ff;
      have_in = have_ff;
      if (push) begin
         prev_lat_in = lat;
         prev_lon_in = lon;
         have_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_lat_ff <= '0;
         prev_lon_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         prev_lat_ff <= prev_lat_in;
         prev_lon_ff <= prev_lon_in;
         have_ff <= have_in;
      end
   end

endmodule

FILE: sv/gcrl_queue.sv
// Two-entry queue between the input side and the compute engine.
module gcrl_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  gcrl_pkg::entry_type      push_entry,
   input  logic                     pop,
   output gcrl_pkg::entry_type      pop_entry,
   output gcrl_pkg::queue_stat_type q_stat
);

   gcrl_pkg::entry_type mem_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_stat.full = count_ff == 2'd2;
   assign q_stat.empty = count_ff == 2'd0;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: sv/gcrl_back.sv
// Compute engine: sine, cosine and arc cosine on one shared multiplier, plus the route total.
module gcrl_back #(
   parameter int ANGLE_FRAC_BITS = gcrl_pkg::DEFAULT_ANGLE_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gcrl_pkg::queue_stat_type q_stat,
   input  gcrl_pkg::entry_type      pop_entry,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [gcrl_pkg::SEG_W-1:0]   rsp_seg,
   output logic [gcrl_pkg::TOTAL_W-1:0] rsp_total,
   output logic                     rsp_sat
);

   localparam int WORD_W = 36;
   localparam int PROD_W = 2 * WORD_W;
   localparam logic signed [WORD_W-1:0] Q90 = WORD_W'(longint'(90) << ANGLE_FRAC_BITS);
   localparam logic signed [WORD_W-1:0] HALF_Q = WORD_W'(longint'(45) << ANGLE_FRAC_BITS);
   localparam logic signed [WORD_W-1:0] Q180 = WORD_W'(longint'(180) << ANGLE_FRAC_BITS);
   localparam logic signed [WORD_W-1:0] Q270 = WORD_W'(longint'(270) << ANGLE_FRAC_BITS);
   localparam logic signed [WORD_W-1:0] FULL = WORD_W'(longint'(360) << ANGLE_FRAC_BITS);
   localparam logic signed [WORD_W-1:0] ONE = WORD_W'(longint'(1) << 30);
   localparam logic signed [WORD_W-1:0] DEG2RAD = WORD_W'(74961321);
   localparam logic signed [WORD_W-1:0] RADIUS = WORD_W'(6531469);
   localparam logic [32:0] PI_C = 33'd3373259426;
   localparam logic [31:0] PI_HALF = 32'd1686629713;
   localparam logic [31:0] PI_QUARTER = 32'd843314856;
   localparam logic [gcrl_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

   // Reciprocals ceil(2^s / d) with s = 31 + ceil(log2(d)); exact for dividends below 2^31.
   localparam logic signed [WORD_W-1:0] RCP_2 = WORD_W'(((64'd1 << 32) + 64'd1) / 64'd2);
   localparam logic signed [WORD_W-1:0] RCP_6 = WORD_W'(((64'd1 << 34) + 64'd5) / 64'd6);
   localparam logic signed [WORD_W-1:0] RCP_12 = WORD_W'(((64'd1 << 35) + 64'd11) / 64'd12);
   localparam logic signed [WORD_W-1:0] RCP_20 = WORD_W'(((64'd1 << 36) + 64'd19) / 64'd20);
   localparam logic signed [WORD_W-1:0] RCP_30 = WORD_W'(((64'd1 << 36) + 64'd29) / 64'd30);
   localparam logic signed [WORD_W-1:0] RCP_42 = WORD_W'(((64'd1 << 37) + 64'd41) / 64'd42);
   localparam logic signed [WORD_W-1:0] RCP_56 = WORD_W'(((64'd1 << 37) + 64'd55) / 64'd56);
   localparam logic signed [WORD_W-1:0] RCP_72 = WORD_W'(((64'd1 << 38) + 64'd71) / 64'd72);
   localparam logic signed [WORD_W-1:0] RCP_90 = WORD_W'(((64'd1 << 38) + 64'd89) / 64'd90);

   typedef enum logic [17:0] {
      ST_IDLE     = 18'h00001,
      ST_RED      = 18'h00002,
      ST_QUAD     = 18'h00004,
      ST_RR       = 18'h00008,
      ST_SER_INIT = 18'h00010,
      ST_SER_MUL  = 18'h00020,
      ST_SER_DIV  = 18'h00040,
      ST_SC_SIN   = 18'h00080,
      ST_SC_COS   = 18'h00100,
      ST_ARG1     = 18'h00200,
      ST_ARG2     = 18'h00400,
      ST_ARG3     = 18'h00800,
      ST_ARG4     = 18'h01000,
      ST_ACOS_BIT = 18'h02000,
      ST_ACOS_CMP = 18'h04000,
      ST_SEG_MUL  = 18'h08000,
      ST_SEG_FIN  = 18'h10000,
      ST_OUT      = 18'h20000
   } state_type;

   function automatic logic signed [WORD_W-1:0] term_rcp(input logic is_cos,
                                                         input logic [2:0] k);
      logic signed [WORD_W-1:0] r;
      r = RCP_2;
      case ({is_cos, k})
         4'b0001: r = RCP_6;
         4'b0010: r = RCP_20;
         4'b0011: r = RCP_42;
         4'b0100: r = RCP_72;
         4'b1001: r = RCP_2;
         4'b1010: r = RCP_12;
         4'b1011: r = RCP_30;
         4'b1100: r = RCP_56;
         4'b1101: r = RCP_90;
         default: r = RCP_2;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] term_shift(input logic is_cos, input logic [2:0] k);
      logic [5:0] s;
      s = 6'd32;
      case ({is_cos, k})
         4'b0001: s = 6'd34;
         4'b0010: s = 6'd36;
         4'b0011: s = 6'd37;
         4'b0100: s = 6'd38;
         4'b1001: s = 6'd32;
         4'b1010: s = 6'd35;
         4'b1011: s = 6'd36;
         4'b1100: s = 6'd37;
         4'b1101: s = 6'd38;
         default: s = 6'd32;
      endcase
      return s;
   endfunction

   state_type state_ff, state_in, ret_ff, ret_in;
   gcrl_pkg::entry_type ent_ff, ent_in;
   logic [1:0] idx_ff, idx_in, q_ff, q_in;
   logic signed [WORD_W-1:0] m_ff, m_in, a_ff, a_in, b_ff, b_in;
   logic signed [WORD_W-1:0] x_ff, x_in, x2_ff, x2_in, s_ff, s_in;
   logic signed [WORD_W-1:0] stmp_ff, stmp_in, acc_ff, acc_in, arg_ff, arg_in;
   logic signed [WORD_W-1:0] sn_ff [3];
   logic signed [WORD_W-1:0] cs_ff [3];
   logic signed [WORD_W-1:0] sn_w, cs_w;
   logic sc_we;
   logic is_cos_ff, is_cos_in, neg_ff, neg_in, dneg_ff, dneg_in;
   logic [2:0] k_ff, k_in;
   logic [5:0] sh_ff, sh_in;
   logic [31:0] th_ff, th_in, cand_ff, cand_in;
   logic [4:0] bit_ff, bit_in;
   logic [gcrl_pkg::SEG_W-1:0] seg_ff, seg_in;
   logic [gcrl_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic rv_ff, rv_in;
   logic [gcrl_pkg::SEG_W-1:0] rseg_ff, rseg_in;
   logic [gcrl_pkg::TOTAL_W-1:0] rtot_ff, rtot_in;
   logic rsat_ff, rsat_in;

   logic signed [PROD_W-1:0] mul_p;
   logic signed [WORD_W-1:0] mulq, pr, mag, qs, tnew, vcos, rr, mh, arg_raw;
   logic [2:0] qc;
   logic [32:0] cand;
   logic [31:0] tred;
   logic [gcrl_pkg::TOTAL_W:0] sum;

   assign mul_p = a_ff * b_ff;
   assign mulq = WORD_W'(mul_p >>> 30);
   assign pop = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp_tvalid = rv_ff;
   assign rsp_seg = rseg_ff;
   assign rsp_total = rtot_ff;
   assign rsp_sat = rsat_ff;

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; ent_in = ent_ff;
      idx_in = idx_ff; q_in = q_ff; m_in = m_ff; a_in = a_ff; b_in = b_ff;
      x_in = x_ff; x2_in = x2_ff; s_in = s_ff; stmp_in = stmp_ff;
      acc_in = acc_ff; arg_in = arg_ff; is_cos_in = is_cos_ff; neg_in = neg_ff;
      dneg_in = dneg_ff; k_in = k_ff; sh_in = sh_ff; th_in = th_ff; cand_in = cand_ff;
      bit_in = bit_ff; seg_in = seg_ff; total_in = total_ff;
      rv_in = rv_ff && !rsp_tready; rseg_in = rseg_ff; rtot_in = rtot_ff; rsat_in = rsat_ff;
      sc_we = 1'b0; sn_w = stmp_ff; cs_w = s_ff;
      pr = mulq; mag = pr[WORD_W-1] ? -pr : pr;
      qs = WORD_W'(mul_p >>> sh_ff);
      tnew = dneg_ff ? qs : -qs;
      vcos = neg_ff ? -s_ff : s_ff;
      rr = WORD_W'(mul_p >>> (ANGLE_FRAC_BITS + 2));
      mh = m_ff + HALF_Q;
      qc = 3'(mh >= Q90) + 3'(mh >= Q180) + 3'(mh >= Q270) + 3'(mh >= FULL);
      arg_raw = acc_ff + mulq;
      cand = {1'b0, th_ff} | (33'd1 << bit_ff);
      tred = (cand[31:0] > PI_HALF) ? (PI_C[31:0] - cand[31:0]) : cand[31:0];
      sum = {1'b0, total_ff} + (gcrl_pkg::TOTAL_W+1)'(seg_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               ent_in = pop_entry;
               seg_in = '0;
               unique case (pop_entry.kind)
                  gcrl_pkg::KIND_START: begin
                     total_in = '0;
                     state_in = ST_OUT;
                  end
                  gcrl_pkg::KIND_SEGMENT: begin
                     idx_in = 2'd0;
                     m_in = WORD_W'(pop_entry.lat1);
                     state_in = ST_RED;
                  end
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_RED: begin
            if (m_ff < 0) begin
               m_in = m_ff + FULL;
            end else if (m_ff >= FULL) begin
               m_in = m_ff - FULL;
            end else begin
               state_in = ST_QUAD;
            end
         end
         ST_QUAD: begin
            q_in = qc[1:0];
            case (qc)
               3'd0: a_in = m_ff;
               3'd1: a_in = m_ff - Q90;
               3'd2: a_in = m_ff - Q180;
               3'd3: a_in = m_ff - Q270;
               default: a_in = m_ff - FULL;
            endcase
            b_in = DEG2RAD;
            state_in = ST_RR;
         end
         ST_RR: begin
            x_in = rr; a_in = rr; b_in = rr;
            is_cos_in = 1'b0; ret_in = ST_SC_SIN; state_in = ST_SER_INIT;
         end
         ST_SER_INIT: begin
            x2_in = mulq;
            s_in = is_cos_ff ? ONE : x_ff;
            a_in = is_cos_ff ? ONE : x_ff;
            b_in = mulq;
            k_in = 3'd1;
            state_in = ST_SER_MUL;
         end
         ST_SER_MUL: begin
            dneg_in = pr[WORD_W-1];
            a_in = mag;
            b_in = term_rcp(is_cos_ff, k_ff);
            sh_in = term_shift(is_cos_ff, k_ff);
            state_in = ST_SER_DIV;
         end
         ST_SER_DIV: begin
            s_in = s_ff + tnew;
            if (k_ff == (is_cos_ff ? 3'd5 : 3'd4)) begin
               state_in = ret_ff;
            end else begin
               k_in = k_ff + 3'd1;
               a_in = tnew; b_in = x2_ff;
               state_in = ST_SER_MUL;
            end
         end
         ST_SC_SIN: begin
            stmp_in = s_ff;
            a_in = x_ff; b_in = x_ff;
            is_cos_in = 1'b1; ret_in = ST_SC_COS; state_in = ST_SER_INIT;
         end
         ST_SC_COS: begin
            sc_we = 1'b1;
            case (q_ff)
               2'd0: begin sn_w = stmp_ff; cs_w = s_ff; end
               2'd1: begin sn_w = s_ff; cs_w = -stmp_ff; end
               2'd2: begin sn_w = -stmp_ff; cs_w = -s_ff; end
               default: begin sn_w = -s_ff; cs_w = stmp_ff; end
            endcase
            if (idx_ff == 2'd2) begin
               state_in = ST_ARG1;
            end else begin
               idx_in = idx_ff + 2'd1;
               m_in = (idx_ff == 2'd0) ? WORD_W'(ent_ff.lat2) : WORD_W'(ent_ff.dlon);
               state_in = ST_RED;
            end
         end
         ST_ARG1: begin
            a_in = sn_ff[0]; b_in = sn_ff[1]; state_in = ST_ARG2;
         end
         ST_ARG2: begin
            acc_in = mulq; a_in = cs_ff[0]; b_in = cs_ff[1]; state_in = ST_ARG3;
         end
         ST_ARG3: begin
            a_in = mulq; b_in = cs_ff[2]; state_in = ST_ARG4;
         end
         ST_ARG4: begin
            if (arg_raw > ONE) begin
               arg_in = ONE;
            end else if (arg_raw < -ONE) begin
               arg_in = -ONE;
            end else begin
               arg_in = arg_raw;
            end
            th_in = '0; bit_in = 5'd31; state_in = ST_ACOS_BIT;
         end
         ST_ACOS_BIT: begin
            if (cand > PI_C) begin
               if (bit_ff == '0) begin
                  state_in = ST_SEG_MUL;
               end else begin
                  bit_in = bit_ff - 5'd1;
               end
            end else begin
               cand_in = cand[31:0];
               neg_in = cand[31:0] > PI_HALF;
               if (tred > PI_QUARTER) begin
                  x_in = $signed({4'b0, PI_HALF - tred});
                  a_in = $signed({4'b0, PI_HALF - tred});
                  b_in = $signed({4'b0, PI_HALF - tred});
                  is_cos_in = 1'b0;
               end else begin
                  x_in = $signed({4'b0, tred});
                  a_in = $signed({4'b0, tred});
                  b_in = $signed({4'b0, tred});
                  is_cos_in = 1'b1;
               end
               ret_in = ST_ACOS_CMP; state_in = ST_SER_INIT;
            end
         end
         ST_ACOS_CMP: begin
            if (vcos >= arg_ff) begin
               th_in = cand_ff;
            end
            if (bit_ff == '0) begin
               state_in = ST_SEG_MUL;
            end else begin
               bit_in = bit_ff - 5'd1;
               state_in = ST_ACOS_BIT;
            end
         end
         ST_SEG_MUL: begin
            a_in = $signed({4'b0, th_ff}); b_in = RADIUS; state_in = ST_SEG_FIN;
         end
         ST_SEG_FIN: begin
            seg_in = gcrl_pkg::SEG_W'((mul_p + PROD_W'(64'd536870912)) >>> 30);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_tready) begin
               total_in = sum[gcrl_pkg::TOTAL_W] ? TOTAL_MAX : sum[gcrl_pkg::TOTAL_W-1:0];
               rv_in = 1'b1;
               rseg_in = seg_ff;
               rtot_in = total_in;
               rsat_in = total_in == TOTAL_MAX;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in; ent_ff <= ent_in; idx_ff <= idx_in; q_ff <= q_in;
      m_ff <= m_in; a_ff <= a_in; b_ff <= b_in; x_ff <= x_in; x2_ff <= x2_in;
      s_ff <= s_in; stmp_ff <= stmp_in; acc_ff <= acc_in; arg_ff <= arg_in;
      is_cos_ff <= is_cos_in; neg_ff <= neg_in; dneg_ff <= dneg_in; k_ff <= k_in;
      sh_ff <= sh_in;
      th_ff <= th_in; cand_ff <= cand_in; bit_ff <= bit_in; seg_ff <= seg_in;
      rseg_ff <= rseg_in; rtot_ff <= rtot_in; rsat_ff <= rsat_in;
      if (sc_we) begin
         sn_ff[idx_ff] <= sn_w;
         cs_ff[idx_ff] <= cs_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         rv_ff <= rv_in;
      end
   end

endmodule

FILE: sv/great_circle_route_length_core.sv
// Top level of the great-circle route length core.
// Waypoints arrive on the req_ stream: tdata carries latitude and longitude
// in degrees with ANGLE_FRAC_BITS fractional bits, and tuser marks the first
// waypoint of a new route. Each waypoint transfer yields exactly one rsp_
// transfer carrying the segment distance and the running route total in
// kilometers times 1024, with tuser set while the total is saturated.
// A route start or the first waypoint after reset skips the computation and
// goes from the queue straight to the output state when the engine is idle.
// For a segment, three sine and cosine evaluations and up to 32 arc cosine
// trial bits each run a power series, and every series term uses the shared
// multiplier twice, once for the product and once for the division by a
// reciprocal multiplication.
// One item is computed at a time; a two-entry queue lets the input side
// take two more waypoints while the engine works.
// Reset clears the previous waypoint, the route total and all valid flags.
// When the receiver stalls, the result holds in the output register, and the
// engine waits with its next result until that register is free.
module great_circle_route_length_core #(
   parameter int ANGLE_FRAC_BITS = gcrl_pkg::DEFAULT_ANGLE_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // latitude [27:0], longitude [56:28], zero fill [63:57]
   input  logic [gcrl_pkg::REQ_DATA_W-1:0] req_tdata,
   // route_start [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // segment_distance [24:0], route_total [64:25], zero fill [71:65]
   output logic [gcrl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // total_saturated [0]
   output logic                            rsp_tuser
);

   gcrl_pkg::queue_stat_type q_stat;
   gcrl_pkg::entry_type push_entry, pop_entry;
   logic push, pop;
   logic [gcrl_pkg::SEG_W-1:0] rsp_seg;
   logic [gcrl_pkg::TOTAL_W-1:0] rsp_total;

   gcrl_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .q_stat, .push, .push_entry
   );

   gcrl_queue u_queue (
      .clock, .reset, .push, .push_entry, .pop, .pop_entry, .q_stat
   );

   gcrl_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
      .clock, .reset, .q_stat, .pop_entry, .pop, .rsp_tvalid, .rsp_tready,
      .rsp_seg, .rsp_total, .rsp_sat(rsp_tuser)
   );

   assign rsp_tdata = {7'b0, rsp_total, rsp_seg};

endmodule

FILE: sv/gcrl_checker.sv
// Port-level checks of the great-circle route length core, bound to the top level.
module gcrl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gcrl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result transfer changed.");

   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == (rsp_tdata[64:25] == 40'hFF_FFFF_FFFF))
      else $error("Saturation flag disagrees with the route total.");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[24:0] <= 25'd20519400 && rsp_tdata[71:65] == 7'd0)
      else $error("Segment distance beyond half the circumference.");

   a_ctrl_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tready, rsp_tvalid}))
      else $error("Handshake output is unknown.");

endmodule

bind great_circle_route_length_core gcrl_checker u_gcrl_checker (.*);
